@@ design/bmtp_pkg.sv @@
// bmtp_pkg: shared types, constants and the sine table of the ball model
// transition probability block; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bmtp_pkg;

  localparam int ROBOTS_PER_TEAM_DEF = 16;
  localparam int ANGLE_BITS_DEF      = 12;

  localparam logic [11:0] NEAR_RADIUS_RESET = 12'd500;
  localparam logic [14:0] PROB_HIGH = 15'd27853;
  localparam logic [14:0] PROB_LOW  = 15'd4915;
  localparam logic [14:0] PROB_ZERO = 15'd0;
  localparam logic [29:0] MOUTH_COS2_Q30 = 30'd537298437;

  localparam logic [3:0] MODEL_SLIDE  = 4'd0;
  localparam logic [3:0] MODEL_ROLL   = 4'd1;
  localparam logic [3:0] MODEL_BOUNCE = 4'd2;
  localparam logic [3:0] MODEL_STOP   = 4'd3;
  localparam logic [3:0] MODEL_KICK_LO  = 4'd4;
  localparam logic [3:0] MODEL_KICK_HI  = 4'd6;
  localparam logic [3:0] MODEL_ROBOT_LO = 4'd7;
  localparam logic [3:0] MODEL_ROBOT_HI = 4'd9;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic REG_NEAR_RADIUS = 1'b0;

  localparam logic [16:0] QSIN [17] = '{
    17'd0, 17'd3212, 17'd6393, 17'd9512, 17'd12540, 17'd15447, 17'd18205,
    17'd20788, 17'd23170, 17'd25330, 17'd27246, 17'd28899, 17'd30274,
    17'd31357, 17'd32138, 17'd32610, 17'd32768
  };

  typedef struct packed {
    logic               present;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [11:0]        heading;
  } robot_t;

  typedef struct packed {
    logic               found;
    logic [6:0]         slot;
    logic [32:0]        d2;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [11:0]        heading;
  } best_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_DONE
  } state_t;

  // sine of a 16-bit phase in q15, quarter-wave table with interpolation
  function automatic logic signed [16:0] sine16(input logic [15:0] p);
    logic [1:0]  q;
    logic [14:0] u;
    logic [3:0]  idx;
    logic [16:0] a;
    logic [16:0] b;
    logic [21:0] tmp;
    logic [16:0] v;
    q = p[15:14];
    u = q[0] ? 15'(15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
    idx = u[13:10];
    a = QSIN[5'(idx)];
    b = QSIN[5'(idx) + 5'd1];
    tmp = 22'(b - a) * 22'(u[9:0]) + 22'd512;
    if (u[14]) begin
      v = 17'd32768;
    end else begin
      v = a + 17'(tmp >> 10);
    end
    return q[1] ? $signed(17'(17'd0 - v)) : $signed(v);
  endfunction

endpackage
`default_nettype wire

@@ design/bmtp_cell.sv @@
// bmtp_cell: one robot slot of the rotating table
// depends on bmtp_pkg
`timescale 1ns / 1ps
`default_nettype none
module bmtp_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            shift,
  input  wire logic            wr_en,
  input  wire bmtp_pkg::robot_t wr_data,
  input  wire bmtp_pkg::robot_t nbr,
  output bmtp_pkg::robot_t     entry
);

  bmtp_pkg::robot_t entry_r;

  // only the present bit needs a reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.present <= 1'b0;
    end else if (shift) begin
      entry_r <= nbr;
    end else if (wr_en) begin
      entry_r <= wr_data;
    end
  end

  assign entry = entry_r;

endmodule
`default_nettype wire

@@ design/bmtp_chain.sv @@
// bmtp_chain: ring of robot cells, rotates one slot a cycle during a scan
// depends on bmtp_pkg and bmtp_cell
`timescale 1ns / 1ps
`default_nettype none
module bmtp_chain #(
  parameter int N = 2 * bmtp_pkg::ROBOTS_PER_TEAM_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             shift,
  input  wire logic             wr_en,
  input  wire logic [4:0]       wr_slot,
  input  wire bmtp_pkg::robot_t wr_data,
  output bmtp_pkg::robot_t      head
);

  bmtp_pkg::robot_t ent [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    bmtp_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (shift),
      .wr_en   (wr_en && (7'(wr_slot) == 7'(i))),
      .wr_data (wr_data),
      .nbr     (ent[(i + 1) % N]),
      .entry   (ent[i])
    );
  end

  // slot k sits in cell 0 while the scan count is k; a full turn brings it home
  assign head = ent[0];

endmodule
`default_nettype wire

@@ design/bmtp_dist.sv @@
// bmtp_dist: three-stage squared-distance pipeline with running nearest pick
// depends on bmtp_pkg
`timescale 1ns / 1ps
`default_nettype none
module bmtp_dist #(
  parameter int SW = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               clr,
  input  wire logic               cap,
  input  wire logic [SW-1:0]      idx,
  input  wire bmtp_pkg::robot_t   entry,
  input  wire logic signed [15:0] bx,
  input  wire logic signed [15:0] by,
  output bmtp_pkg::best_t         best
);

  logic               a_vld_r, b_vld_r;
  logic [SW-1:0]      a_idx_r, b_idx_r;
  logic signed [16:0] a_dx_r, a_dy_r, b_dx_r, b_dy_r;
  logic [11:0]        a_hd_r, b_hd_r;
  logic signed [33:0] b_dxsq_r, b_dysq_r;
  logic [32:0]        d2;
  bmtp_pkg::best_t    best_r;

  assign d2 = {1'b0, b_dxsq_r[31:0]} + {1'b0, b_dysq_r[31:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= cap && entry.present;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_idx_r  <= idx;
    a_dx_r   <= $signed({bx[15], bx}) - $signed({entry.x[15], entry.x});
    a_dy_r   <= $signed({by[15], by}) - $signed({entry.y[15], entry.y});
    a_hd_r   <= entry.heading;
    b_idx_r  <= a_idx_r;
    b_dx_r   <= a_dx_r;
    b_dy_r   <= a_dy_r;
    b_hd_r   <= a_hd_r;
    b_dxsq_r <= a_dx_r * a_dx_r;
    b_dysq_r <= a_dy_r * a_dy_r;
    if (!rst_n) begin
      best_r.found <= 1'b0;
    end else if (clr) begin
      best_r.found <= 1'b0;
      best_r.slot  <= 7'd0;
    end else if (b_vld_r && (!best_r.found || d2 < best_r.d2)) begin
      best_r.found   <= 1'b1;
      best_r.slot    <= 7'(b_idx_r);
      best_r.d2      <= d2;
      best_r.dx      <= b_dx_r;
      best_r.dy      <= b_dy_r;
      best_r.heading <= b_hd_r;
    end
  end

  assign best = best_r;

endmodule
`default_nettype wire

@@ design/ball_model_transition_prob_top.sv @@
// ball_model_transition_prob_top: robot table ring, distance scan and the
// transition rules; depends on bmtp_pkg, bmtp_chain and bmtp_dist
//
//   channel  | handshake              | payload
//   input    | start / busy           | in_mode .. in_to_model
//   result   | out_valid (strobe)     | out_probability, out_nearest_*
//   config   | psel/penable/pwrite    | paddr, pwdata, prdata
//
// a load writes its slot and leaves busy low. in a query the ring rotates
// the table past one distance unit a cycle, the three-stage distance
// pipeline drains, five steps work out near, toward and the mouth cone,
// and the result strobes in the same cycle that busy falls.
// reset empties every slot and sets near_radius_mm to 500. the receiver
// cannot stall, so out_valid is a one-cycle pulse.
`timescale 1ns / 1ps
`default_nettype none
module ball_model_transition_prob_top #(
  parameter int ROBOTS_PER_TEAM = bmtp_pkg::ROBOTS_PER_TEAM_DEF,
  parameter int ANGLE_BITS      = bmtp_pkg::ANGLE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_mode,
  input  wire logic [4:0]         in_robot_slot,
  input  wire logic               in_robot_present,
  input  wire logic signed [15:0] in_robot_x,
  input  wire logic signed [15:0] in_robot_y,
  input  wire logic [11:0]        in_robot_heading,
  input  wire logic signed [15:0] in_ball_x,
  input  wire logic signed [15:0] in_ball_y,
  input  wire logic signed [15:0] in_ball_vx,
  input  wire logic signed [15:0] in_ball_vy,
  input  wire logic [3:0]         in_from_model,
  input  wire logic [3:0]         in_to_model,
  output logic                    out_valid,
  output logic [14:0]             out_probability,
  output logic                    out_nearest_found,
  output logic [4:0]              out_nearest_slot,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int N  = 2 * ROBOTS_PER_TEAM;
  localparam int SW = (N > 1) ? $clog2(N) : 1;
  localparam int CW = $clog2(N + 2);

  bmtp_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             accept, scan_cap, load_wr, clr;

  logic [11:0]        rad_r;
  logic signed [15:0] bx_r, by_r, vx_r, vy_r;
  logic [3:0]         from_r, to_r;

  bmtp_pkg::robot_t head, wr_data;
  bmtp_pkg::best_t  best;

  logic signed [16:0] s_r, c_r;
  logic [23:0]        rr_r;
  logic               near_r, toward_r, dpos_r, mouth_r;
  logic signed [33:0] pa_r, pb_r;
  logic signed [32:0] tva_r, tvb_r;
  logic signed [33:0] tv_sum;
  logic signed [34:0] d_r;
  logic [33:0]        hh_r, hl_r, ll_r;
  logic [46:0]        kl_r;
  logic [45:0]        kh_r;
  logic [67:0]        lhs, rhs;
  logic [15:0]        ph, cph;
  logic [33:0]        ud;

  logic        out_valid_r;
  logic [14:0] prob_r, prob;
  logic        found_r;
  logic [4:0]  slot_r;
  logic        to_kick, src_kick, from_rob, to_rob, nr, tw, mo;

  assign accept   = start && !busy;
  assign load_wr  = accept && (in_mode == bmtp_pkg::MODE_LOAD) && (7'(in_robot_slot) < 7'(N));
  assign clr      = accept && (in_mode == bmtp_pkg::MODE_QUERY);
  assign scan_cap = (state_r == bmtp_pkg::ST_SCAN) && (cnt_r < CW'(N));
  assign busy     = (state_r != bmtp_pkg::ST_IDLE);

  assign wr_data.present = in_robot_present;
  assign wr_data.x       = in_robot_x;
  assign wr_data.y       = in_robot_y;
  assign wr_data.heading = in_robot_heading;

  bmtp_chain #(.N(N)) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .shift   (scan_cap),
    .wr_en   (load_wr),
    .wr_slot (in_robot_slot),
    .wr_data (wr_data),
    .head    (head)
  );

  bmtp_dist #(.SW(SW)) u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (clr),
    .cap   (scan_cap),
    .idx   (cnt_r[SW-1:0]),
    .entry (head),
    .bx    (bx_r),
    .by    (by_r),
    .best  (best)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bmtp_pkg::REG_NEAR_RADIUS) ? {20'd0, rad_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r <= bmtp_pkg::NEAR_RADIUS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == bmtp_pkg::REG_NEAR_RADIUS) begin
      rad_r <= pwdata[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmtp_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      bmtp_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (clr) state_nxt = bmtp_pkg::ST_SCAN;
      end
      bmtp_pkg::ST_SCAN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(N + 1)) state_nxt = bmtp_pkg::ST_P1;
      end
      bmtp_pkg::ST_P1:   state_nxt = bmtp_pkg::ST_P2;
      bmtp_pkg::ST_P2:   state_nxt = bmtp_pkg::ST_P3;
      bmtp_pkg::ST_P3:   state_nxt = bmtp_pkg::ST_P4;
      bmtp_pkg::ST_P4:   state_nxt = bmtp_pkg::ST_P5;
      bmtp_pkg::ST_P5:   state_nxt = bmtp_pkg::ST_DONE;
      bmtp_pkg::ST_DONE: state_nxt = bmtp_pkg::ST_IDLE;
      default:           state_nxt = bmtp_pkg::ST_IDLE;
    endcase
  end

  // heading to a 16-bit phase
  assign ph  = 16'((32'(best.heading) & ((32'd1 << ANGLE_BITS) - 32'd1)) << (16 - ANGLE_BITS));
  assign cph = ph + 16'd16384;

  assign tv_sum = tva_r + tvb_r;
  assign ud     = d_r[33:0];
  assign lhs = (68'(hh_r) << 34) + (68'(hl_r) << 18) + 68'(ll_r);
  assign rhs = (68'(kh_r) << 17) + 68'(kl_r);

  always_ff @(posedge clk) begin
    if (clr) begin
      bx_r   <= in_ball_x;
      by_r   <= in_ball_y;
      vx_r   <= in_ball_vx;
      vy_r   <= in_ball_vy;
      from_r <= in_from_model;
      to_r   <= in_to_model;
    end
    case (state_r)
      bmtp_pkg::ST_P1: begin
        s_r  <= bmtp_pkg::sine16(ph);
        c_r  <= bmtp_pkg::sine16(cph);
        rr_r <= rad_r * rad_r;
      end
      bmtp_pkg::ST_P2: begin
        near_r <= best.d2 < 33'(rr_r);
        pa_r   <= c_r * best.dx;
        pb_r   <= s_r * best.dy;
        tva_r  <= best.dx * vx_r;
        tvb_r  <= best.dy * vy_r;
      end
      bmtp_pkg::ST_P3: begin
        d_r      <= pa_r + pb_r;
        toward_r <= tv_sum[33];
      end
      bmtp_pkg::ST_P4: begin
        // zero vector means ball on the robot centre
        dpos_r <= !d_r[34] && (d_r != '0) && (best.d2 != '0);
        hh_r   <= ud[33:17] * ud[33:17];
        hl_r   <= ud[33:17] * ud[16:0];
        ll_r   <= ud[16:0] * ud[16:0];
        kl_r   <= bmtp_pkg::MOUTH_COS2_Q30 * best.d2[16:0];
        kh_r   <= bmtp_pkg::MOUTH_COS2_Q30 * best.d2[32:17];
      end
      bmtp_pkg::ST_P5: begin
        mouth_r <= dpos_r && (lhs > rhs);
      end
      default: begin
      end
    endcase
  end

  // transition rules, first match wins
  always_comb begin
    to_kick   = (to_r >= bmtp_pkg::MODEL_KICK_LO) && (to_r <= bmtp_pkg::MODEL_KICK_HI);
    src_kick  = (from_r >= bmtp_pkg::MODEL_KICK_LO) && (from_r <= bmtp_pkg::MODEL_KICK_HI);
    to_rob    = (to_r >= bmtp_pkg::MODEL_ROBOT_LO) && (to_r <= bmtp_pkg::MODEL_ROBOT_HI);
    from_rob  = (from_r >= bmtp_pkg::MODEL_ROBOT_LO) && (from_r <= bmtp_pkg::MODEL_ROBOT_HI);
    nr = best.found && near_r;
    tw = best.found && toward_r;
    mo = best.found && mouth_r;
    if (from_r == to_r) prob = bmtp_pkg::PROB_HIGH;
    else if (from_r == bmtp_pkg::MODEL_SLIDE && to_r == bmtp_pkg::MODEL_ROLL)
      prob = bmtp_pkg::PROB_LOW;
    else if (nr && tw && to_r == bmtp_pkg::MODEL_BOUNCE) prob = bmtp_pkg::PROB_LOW;
    else if (nr && tw && mo && to_r == bmtp_pkg::MODEL_STOP) prob = bmtp_pkg::PROB_LOW;
    else if (nr && mo && to_kick) prob = bmtp_pkg::PROB_LOW;
    else if (src_kick && to_r == bmtp_pkg::MODEL_SLIDE) prob = bmtp_pkg::PROB_HIGH;
    else if (from_rob && to_rob) prob = bmtp_pkg::PROB_LOW;
    else prob = bmtp_pkg::PROB_ZERO;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == bmtp_pkg::ST_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bmtp_pkg::ST_DONE) begin
      prob_r  <= prob;
      found_r <= best.found;
      slot_r  <= best.slot[4:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_probability   = prob_r;
  assign out_nearest_found = found_r;
  assign out_nearest_slot  = slot_r;

`ifndef SYNTHESIS
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == bmtp_pkg::MODE_QUERY) |=> busy)
    else $error("query request did not raise busy");
  a_prob_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_probability == bmtp_pkg::PROB_HIGH ||
                   out_probability == bmtp_pkg::PROB_LOW ||
                   out_probability == bmtp_pkg::PROB_ZERO))
    else $error("probability outside its three codes");
`endif

endmodule
`default_nettype wire

@@ sim/bmtp_checker.sv @@
// bmtp_checker: watches the request, result and config channels of the ball model
// transition probability block, predicts each query result and compares it;
// depends on bmtp_pkg for the probability and model constants
`timescale 1ns / 1ps
module bmtp_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_mode,
  input  logic [4:0]         in_robot_slot,
  input  logic               in_robot_present,
  input  logic signed [15:0] in_robot_x,
  input  logic signed [15:0] in_robot_y,
  input  logic [11:0]        in_robot_heading,
  input  logic signed [15:0] in_ball_x,
  input  logic signed [15:0] in_ball_y,
  input  logic signed [15:0] in_ball_vx,
  input  logic signed [15:0] in_ball_vy,
  input  logic [3:0]         in_from_model,
  input  logic [3:0]         in_to_model,
  input  logic               out_valid,
  input  logic [14:0]        out_probability,
  input  logic               out_nearest_found,
  input  logic [4:0]         out_nearest_slot,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending,
  output int                 verdicts
);
  import bmtp_pkg::*;

  typedef struct packed {
    logic [14:0] prob;
    logic        found;
    logic [4:0]  slot;
  } verdict_t;

  localparam longint QTAB [17] = '{0, 3212, 6393, 9512, 12540, 15447, 18205,
    20788, 23170, 25330, 27246, 28899, 30274, 31357, 32138, 32610, 32768};

  logic        tab_present [32];
  longint      tab_x [32];
  longint      tab_y [32];
  logic [11:0] tab_heading [32];
  logic [11:0] radius;
  verdict_t    verdict_q [$];

  function automatic longint quarter_sin(int unsigned u);
    longint a, b;
    if (u >= 16384) return 32768;
    a = QTAB[u >> 10];
    b = QTAB[(u >> 10) + 1];
    return a + (((b - a) * longint'(u & 1023) + 512) >>> 10);
  endfunction

  function automatic longint phase_sin(int unsigned p);
    int unsigned q, r;
    longint v;
    q = (p >> 14) & 3;
    r = p & 16'h3fff;
    v = q[0] ? quarter_sin(16384 - r) : quarter_sin(r);
    return q[1] ? -v : v;
  endfunction

  function automatic bit is_kick(logic [3:0] m);
    return m >= MODEL_KICK_LO && m <= MODEL_KICK_HI;
  endfunction

  function automatic bit is_robot_model(logic [3:0] m);
    return m >= MODEL_ROBOT_LO && m <= MODEL_ROBOT_HI;
  endfunction

  function automatic verdict_t transition_verdict();
    verdict_t v;
    longint bx, by, vx, vy, rx, ry, s, c, d, rad;
    longint unsigned d2, best_d2, ud, n;
    bit found, near, toward, mouth;
    int best, p;
    logic [3:0] fm, tm;
    bx = longint'(in_ball_x); by = longint'(in_ball_y);
    vx = longint'(in_ball_vx); vy = longint'(in_ball_vy);
    fm = in_from_model; tm = in_to_model;
    found = 0; near = 0; toward = 0; mouth = 0; best = 0; best_d2 = 0;
    for (int i = 0; i < 32; i++) begin
      if (tab_present[i]) begin
        d2 = (bx - tab_x[i]) * (bx - tab_x[i]) + (by - tab_y[i]) * (by - tab_y[i]);
        if (!found || d2 < best_d2) begin
          found = 1; best_d2 = d2; best = i;
        end
      end
    end
    if (found) begin
      rx = bx - tab_x[best];
      ry = by - tab_y[best];
      rad = longint'(radius);
      p = (int'(tab_heading[best]) << 4) & 16'hffff;
      s = phase_sin(p);
      c = phase_sin((p + 16384) & 16'hffff);
      d = c * rx + s * ry;
      near = best_d2 < rad * rad;
      toward = ((-rx) * vx + (-ry) * vy) > 0;
      if ((rx != 0 || ry != 0) && d > 0) begin
        ud = d;
        n = rx * rx + ry * ry;
        mouth = ud * ud > longint'(MOUTH_COS2_Q30) * n;
      end
    end
    if (fm == tm) v.prob = PROB_HIGH;
    else if (fm == MODEL_SLIDE && tm == MODEL_ROLL) v.prob = PROB_LOW;
    else if (near && toward && tm == MODEL_BOUNCE) v.prob = PROB_LOW;
    else if (near && toward && mouth && tm == MODEL_STOP) v.prob = PROB_LOW;
    else if (near && mouth && is_kick(tm)) v.prob = PROB_LOW;
    else if (is_kick(fm) && tm == MODEL_SLIDE) v.prob = PROB_HIGH;
    else if (is_robot_model(fm) && is_robot_model(tm)) v.prob = PROB_LOW;
    else v.prob = PROB_ZERO;
    v.found = found;
    v.slot = 5'(best);
    return v;
  endfunction

  assign pending = verdict_q.size();

  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) begin
        tab_present[i] <= 0; tab_x[i] <= 0; tab_y[i] <= 0; tab_heading[i] <= 0;
      end
      radius <= NEAR_RADIUS_RESET;
      fail_count <= 0;
      verdicts <= 0;
      verdict_q.delete();
    end else begin
      if (out_valid) begin
        got = '{out_probability, out_nearest_found, out_nearest_slot};
        verdicts <= verdicts + 1;
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            $display("%0t: expected %p actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (in_mode == MODE_LOAD) begin
          tab_present[in_robot_slot] <= in_robot_present;
          tab_x[in_robot_slot] <= longint'(in_robot_x);
          tab_y[in_robot_slot] <= longint'(in_robot_y);
          tab_heading[in_robot_slot] <= in_robot_heading;
        end else begin
          verdict_q.push_back(transition_verdict());
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_NEAR_RADIUS)
        radius <= pwdata[11:0];
    end
  end
endmodule

@@ sim/tb.sv @@
// tb: request stimulus, register writes and verdict for the ball model
// transition probability block; depends on bmtp_pkg and bmtp_checker
`timescale 1ns / 1ps
module tb;
  import bmtp_pkg::*;

  logic clk = 0, rst_n = 0, start = 0, busy;
  logic in_mode = 0, in_robot_present = 0;
  logic [4:0] in_robot_slot = 0;
  logic signed [15:0] in_robot_x = 0, in_robot_y = 0;
  logic signed [15:0] in_ball_x = 0, in_ball_y = 0, in_ball_vx = 0, in_ball_vy = 0;
  logic [11:0] in_robot_heading = 0;
  logic [3:0] in_from_model = 0, in_to_model = 0;
  logic out_valid, out_nearest_found;
  logic [14:0] out_probability;
  logic [4:0] out_nearest_slot;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  int fail_count, pending, verdicts, loads, queries;
  logic signed [15:0] cx, cy;

  always #5 clk = ~clk;

  ball_model_transition_prob_top i_dut (.*);
  bmtp_checker i_chk (.*);

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // hold the request until the block takes it, then idle a random while;
  // with no idle time start simply stays high for the next request
  task automatic issue();
    int r, len;
    start <= 1;
    do @(posedge clk); while (busy);
    r = $urandom_range(0, 99);
    len = r < 50 ? 0 : r < 93 ? int'($urandom_range(1, 3)) : int'($urandom_range(10, 60));
    if (len != 0) begin
      start <= 0;
      repeat (len) @(posedge clk);
    end
  endtask

  task automatic load(logic [4:0] s, logic p, logic signed [15:0] x, y, logic [11:0] h);
    in_mode <= MODE_LOAD; in_robot_slot <= s; in_robot_present <= p;
    in_robot_x <= x; in_robot_y <= y; in_robot_heading <= h;
    loads++;
    issue();
  endtask

  task automatic query(logic signed [15:0] x, y, vx, vy, logic [3:0] f, t);
    in_mode <= MODE_QUERY; in_ball_x <= x; in_ball_y <= y;
    in_ball_vx <= vx; in_ball_vy <= vy; in_from_model <= f; in_to_model <= t;
    queries++;
    issue();
  endtask

  task automatic drain();
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_radius(logic [11:0] r);
    psel <= 1; pwrite <= 1; paddr <= 3'd0;
    pwdata <= ($urandom() & 32'hfffff000) | {20'd0, r};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  // near-robot query with random content, mostly well formed
  task automatic near_query();
    cx = 16'(int'($urandom_range(0, 4000)) - 2000);
    cy = 16'(int'($urandom_range(0, 4000)) - 2000);
    if ($urandom_range(0, 3) == 0)
      query(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
            4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    else
      query(cx + 16'($signed(10'($urandom_range(0, 1023)))),
            cy + 16'($signed(10'($urandom_range(0, 1023)))),
            16'($signed(12'($urandom()))), 16'($signed(12'($urandom()))),
            4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: empty table, ties, extremes, every model pair class
    query(0, 0, 0, 0, MODEL_SLIDE, MODEL_ROLL);
    load(3, 1, 100, 0, 0);
    load(1, 1, -100, 0, 12'd2048);
    query(0, 0, 10, 0, MODEL_SLIDE, MODEL_BOUNCE);
    query(-100, 0, 0, 0, MODEL_ROLL, MODEL_STOP);
    query(-50, 0, -5, 0, MODEL_ROLL, MODEL_STOP);
    query(-150, 0, 5, 0, MODEL_SLIDE, MODEL_STOP);
    query(-150, 0, 5, 0, MODEL_SLIDE, 4'd5);
    query(0, 0, 0, 0, 4'd4, MODEL_SLIDE);
    query(0, 0, 0, 0, 4'd7, 4'd9);
    query(0, 0, 0, 0, 4'd15, 4'd15);
    query(0, 0, 0, 0, 4'd12, 4'd2);
    load(31, 1, 16'sh7fff, 16'sh8000, 12'hfff);
    query(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, MODEL_ROLL, 4'd6);
    query(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 4'd8, 4'd7);
    load(1, 0, 0, 0, 0);
    query(-100, 0, 1, 0, MODEL_SLIDE, 4'd2);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_radius(12'd0);
        1: set_radius(12'd4095);
        2: set_radius(12'd500);
        default: set_radius(12'($urandom_range(0, 4095)));
      endcase
      for (int n = 0; n < 380; n++) begin
        if ($urandom_range(0, 3) == 0)
          load(5'($urandom_range(0, 31)), $urandom_range(0, 5) != 0,
               16'(int'($urandom_range(0, 4000)) - 2000),
               16'(int'($urandom_range(0, 4000)) - 2000),
               12'($urandom()));
        else if ($urandom_range(0, 19) == 0)
          load(5'($urandom()), 1'($urandom()), 16'($urandom()), 16'($urandom()),
               12'($urandom()));
        else
          near_query();
      end
      drain();
    end
    if (fail_count == 0) $display("covered %0d loads, %0d queries, %0d results",
                                  loads, queries, verdicts);
    else $display("covered %0d loads, %0d queries", loads, queries);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ ball_model_transition_prob_top.f @@
design/bmtp_pkg.sv
design/bmtp_cell.sv
design/bmtp_chain.sv
design/bmtp_dist.sv
design/ball_model_transition_prob_top.sv
sim/bmtp_checker.sv
sim/tb.sv
